>>> design/bytes_to_base_p_digits_defines.svh
// Assertion macros shared by the base-p digit converter.
`ifndef BYTES_TO_BASE_P_DIGITS_DEFINES_SVH
`define BYTES_TO_BASE_P_DIGITS_DEFINES_SVH

// Same-cycle implication, checked on aclk, muted while aresetn is low.
`define BBPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, muted while aresetn is low.
`define BBPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bbpd_pkg.sv
// Shared constants for the base-p digit converter.
`timescale 1ns / 1ps

package bbpd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LIMB_W  = 16;
    localparam int DIGIT_W = 14;
    localparam int INDEX_W = 5;

    // Default sizes
    localparam int NUM_LIMBS_DEF  = 24;
    localparam int NUM_DIGITS_DEF = 19;

    // Prime modulus
    localparam int unsigned MOD_P = 9767;
    localparam logic [DIGIT_W-1:0] MOD_P_V = DIGIT_W'(MOD_P);

    // Dividend of one division step: remainder above one limb
    localparam int NUM_W = DIGIT_W + LIMB_W;

    // Reciprocal for exact floor division of any NUM_W-bit value by MOD_P
    localparam int RECIP_SHIFT = NUM_W + DIGIT_W;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MOD_P - 1)) / 64'(MOD_P));
    localparam int PROD_W = NUM_W + RECIP_W;

    // 2^32 mod p, the Montgomery scale factor
    localparam logic [DIGIT_W-1:0] MONT_R_MOD = DIGIT_W'((64'd1 << 32) % 64'(MOD_P));

endpackage

>>> design/bbpd_limb_ram.sv
// Limb store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bbpd_limb_ram
    import bbpd_pkg::*;
#(
    parameter int NUM_LIMBS = NUM_LIMBS_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_LIMBS)-1:0] wr_addr,
    input  logic [LIMB_W-1:0]            wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_LIMBS)-1:0] rd_addr,
    output logic [LIMB_W-1:0]            rd_data
);

    logic [LIMB_W-1:0] mem [NUM_LIMBS];
    logic [LIMB_W-1:0] rd_data_reg;

    // Write one limb
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one limb, data valid the next cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bytes_to_base_p_digits.sv
// Top level: converts a 48-byte little-endian integer into Montgomery-form base-9767 digits.
// Load: one byte per cycle while s_ready is high; no result for bytes 1..47.
// Convert: per digit, the three-stage reciprocal divide loop (S_MUL1, S_MUL2,
//   S_SUB) walks the limb RAM serially, top limb first.
// Digits leave least significant first, NUM_DIGITS (19 by default) in all.
// Reset clears control and output valid; the limb RAM keeps its contents.
`timescale 1ns / 1ps
`include "bytes_to_base_p_digits_defines.svh"

module bytes_to_base_p_digits
    import bbpd_pkg::*;
#(
    parameter int NUM_LIMBS  = NUM_LIMBS_DEF,
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIGIT_W-1:0] m_digit,
    output logic [INDEX_W-1:0] m_digit_index,
    output logic               m_last_digit
);

    localparam int AW    = $clog2(NUM_LIMBS);
    localparam int CNT_W = $clog2(2 * NUM_LIMBS);
    localparam logic [AW-1:0]      TOP_LIMB   = AW'(NUM_LIMBS - 1);
    localparam logic [CNT_W-1:0]   LAST_BYTE  = CNT_W'(2 * NUM_LIMBS - 1);
    localparam logic [INDEX_W-1:0] LAST_DIGIT = INDEX_W'(NUM_DIGITS - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_MUL1,
        S_MUL2,
        S_SUB,
        S_TMUL,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     byte_cnt_reg;
    logic [BYTE_W-1:0]    low_byte_reg;
    logic [AW-1:0]        limb_idx_reg;
    logic [INDEX_W-1:0]   digit_idx_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic                 tm_mode_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LIMB_W-1:0]    quot_reg;
    logic [NUM_W-1:0]     qp_reg;
    logic [DIGIT_W-1:0]   pend_digit_reg;
    logic                 m_valid_reg;
    logic [DIGIT_W-1:0]   m_digit_reg;
    logic [INDEX_W-1:0]   m_index_reg;
    logic                 m_last_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [LIMB_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [LIMB_W-1:0]    ram_rdata;

    logic                 s_accept;
    logic                 out_free;
    logic [NUM_W-1:0]     mul_a;
    logic [PROD_W-1:0]    prod_w;
    logic [LIMB_W-1:0]    quot_w;
    logic [NUM_W-1:0]     qp_w;
    logic [NUM_W-1:0]     diff_w;
    logic [DIGIT_W-1:0]   rem_w;
    logic [NUM_W-1:0]     tm_prod_w;

    bbpd_limb_ram #(
        .NUM_LIMBS (NUM_LIMBS)
    ) u_limb_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready  = (state_reg == S_LOAD);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Stage 1: dividend times reciprocal
    assign mul_a  = tm_mode_reg ? num_reg : {rem_reg, ram_rdata};
    assign prod_w = PROD_W'(mul_a) * PROD_W'(RECIP);

    // Stage 2: quotient times p
    assign quot_w = prod_reg[RECIP_SHIFT +: LIMB_W];
    assign qp_w   = NUM_W'(quot_w) * NUM_W'(MOD_P_V);

    // Stage 3: remainder
    assign diff_w = num_reg - qp_reg;
    assign rem_w  = diff_w[DIGIT_W-1:0];

    // Scale the final remainder into Montgomery form before reducing it
    assign tm_prod_w = NUM_W'(rem_reg) * NUM_W'(MONT_R_MOD);

    // Limb RAM access: byte pairs while loading, read-modify-write while dividing
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = limb_idx_reg;
        ram_wdata = quot_reg;
        ram_re    = 1'b0;
        ram_raddr = limb_idx_reg;
        unique case (state_reg)
            S_LOAD: begin
                ram_we    = s_accept && byte_cnt_reg[0];
                ram_waddr = byte_cnt_reg[CNT_W-1:1];
                ram_wdata = {s_data_byte, low_byte_reg};
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_SUB: begin
                if (!tm_mode_reg) begin
                    ram_we = 1'b1;
                    if (limb_idx_reg != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = limb_idx_reg - AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            byte_cnt_reg  <= '0;
            low_byte_reg  <= '0;
            limb_idx_reg  <= '0;
            digit_idx_reg <= '0;
            rem_reg       <= '0;
            tm_mode_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the result once it is taken
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (s_accept) begin
                        if (!byte_cnt_reg[0]) begin
                            low_byte_reg <= s_data_byte;
                        end
                        if (byte_cnt_reg == LAST_BYTE) begin
                            byte_cnt_reg  <= '0;
                            limb_idx_reg  <= TOP_LIMB;
                            digit_idx_reg <= '0;
                            rem_reg       <= '0;
                            tm_mode_reg   <= 1'b0;
                            state_reg     <= S_RD;
                        end else begin
                            byte_cnt_reg <= byte_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    num_reg   <= mul_a;
                    prod_reg  <= prod_w;
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    quot_reg  <= quot_w;
                    qp_reg    <= qp_w;
                    state_reg <= S_SUB;
                end
                S_SUB: begin
                    if (tm_mode_reg) begin
                        // Zero is shown as p
                        pend_digit_reg <= (rem_w == '0) ? MOD_P_V : rem_w;
                        state_reg      <= S_OUT;
                    end else begin
                        rem_reg <= rem_w;
                        if (limb_idx_reg == '0) begin
                            state_reg <= S_TMUL;
                        end else begin
                            limb_idx_reg <= limb_idx_reg - AW'(1);
                            state_reg    <= S_MUL1;
                        end
                    end
                end
                S_TMUL: begin
                    num_reg     <= tm_prod_w;
                    tm_mode_reg <= 1'b1;
                    state_reg   <= S_MUL1;
                end
                S_OUT: begin
                    // Hold the digit until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_digit_reg <= pend_digit_reg;
                        m_index_reg <= digit_idx_reg;
                        m_last_reg  <= (digit_idx_reg == LAST_DIGIT);
                        tm_mode_reg <= 1'b0;
                        rem_reg     <= '0;
                        if (digit_idx_reg == LAST_DIGIT) begin
                            digit_idx_reg <= '0;
                            state_reg     <= S_LOAD;
                        end else begin
                            digit_idx_reg <= digit_idx_reg + INDEX_W'(1);
                            limb_idx_reg  <= TOP_LIMB;
                            state_reg     <= S_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit       = m_digit_reg;
    assign m_digit_index = m_index_reg;
    assign m_last_digit  = m_last_reg;

    // Checks on the divide loop and the result register
    `BBPD_ASSERT_IMP(a_rem_below_p, (state_reg == S_SUB), (diff_w < NUM_W'(MOD_P)), "remainder not below p")
    `BBPD_ASSERT_IMP(a_digit_range, m_valid_reg, ((m_digit_reg != '0) && (m_digit_reg <= MOD_P_V)), "digit out of range")
    `BBPD_ASSERT_IMP(a_last_flag, m_valid_reg, (m_last_reg == (m_index_reg == LAST_DIGIT)), "last flag does not match index")
    `BBPD_ASSERT_NXT(a_start_convert, (s_accept && (byte_cnt_reg == LAST_BYTE)), ((state_reg == S_RD) && (limb_idx_reg == TOP_LIMB)), "conversion did not start at top limb")

endmodule
